// File: hdl/lnpv_pkg.sv
package lnpv_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // "no note" marker for the last note that took the voice
    localparam logic [7:0] NOTE_NONE = 8'hFF;

    // key operations
    localparam logic OP_PRESS   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // voice events
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_GLIDE = 2'd2;
    localparam logic [1:0] EV_STOP  = 2'd3;

    // cell modes
    localparam logic [1:0] CM_HOLD = 2'd0;
    localparam logic [1:0] CM_ROT  = 2'd1;
    localparam logic [1:0] CM_DEL  = 2'd2;
    localparam logic [1:0] CM_INS  = 2'd3;

    // control broadcast to every stack cell
    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] total;
        logic [6:0]       note;
    } t_cell_ctl;

endpackage

// File: hdl/lnpv_if.sv
// key event channel
interface lnpv_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [6:0] note;

    modport source (output valid, output op, output note, input ready);
    modport sink   (input valid, input op, input note, output ready);
endinterface

// voice result channel
interface lnpv_out_if;
    logic       valid;
    logic       ready;
    logic       voice_active;
    logic [6:0] owner_note;
    logic [1:0] voice_event;
    logic [4:0] held_count;

    modport source (output valid, output voice_active, output owner_note,
                    output voice_event, output held_count, input ready);
    modport sink   (input valid, input voice_active, input owner_note,
                    input voice_event, input held_count, output ready);
endinterface

// File: hdl/lnpv_cell.sv
module lnpv_cell
    import lnpv_pkg::*;
(
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  logic [6:0]       i_right,
    output logic [6:0]       o_note
);

    logic [6:0]       r_note;
    logic [6:0]       n_note;
    logic [CNT_W:0]   w_idx_e;
    logic [CNT_W:0]   w_total_e;

    assign w_idx_e   = {{(CNT_W + 1 - IDX_W){1'b0}}, i_index};
    assign w_total_e = {1'b0, i_ctl.total};

    // next held note of this slot
    always_comb begin
        n_note = r_note;
        case (i_ctl.mode)
            CM_ROT: begin
                n_note = i_right;
            end
            CM_DEL: begin
                if ((i_index >= i_ctl.pos) && ((w_idx_e + 1'b1) < w_total_e)) begin
                    n_note = i_right;
                end
            end
            CM_INS: begin
                if (w_idx_e == w_total_e) begin
                    n_note = i_ctl.note;
                end
            end
            default: begin
                n_note = r_note;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_note <= n_note;
    end

    assign o_note = r_note;

endmodule

// File: hdl/lnpv_stack.sv
module lnpv_stack
    import lnpv_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    output logic [6:0] o_head
);

    logic [6:0] w_notes [STACK_DEPTH];

    // ring of slots, each one takes its upper neighbor, the top wraps to slot 0
    for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
        lnpv_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(j)),
            .i_ctl   (i_ctl),
            .i_right (w_notes[(j + 1) % STACK_DEPTH]),
            .o_note  (w_notes[j])
        );
    end

    assign o_head = w_notes[0];

endmodule

// File: hdl/last_note_priority_voice_core.sv
// a key word is taken only in idle; the walk of the stack ring then visits one slot per cycle,
//   then the update step registers the result word; the next key word is taken only after
//   that update, which waits while the sink holds an earlier result word
// reset: synchronous, active low; clears held count, voice state and handshakes,
//   stack slot contents stay undefined until written
module last_note_priority_voice_core
    import lnpv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    lnpv_in_if.sink           i_in,
    lnpv_out_if.source        o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_op, n_op;
    logic [6:0]       r_note, n_note;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_match, n_match;
    logic [6:0]       r_top1, n_top1;
    logic [6:0]       r_top2, n_top2;
    logic [CNT_W-1:0] r_total, n_total;
    logic             r_voice_on, n_voice_on;
    logic [6:0]       r_owner, n_owner;
    logic [7:0]       r_prev, n_prev;
    logic             r_out_valid, n_out_valid;
    logic             r_out_active, n_out_active;
    logic [6:0]       r_out_owner, n_out_owner;
    logic [1:0]       r_out_event, n_out_event;
    logic [4:0]       r_out_count, n_out_count;

    t_cell_ctl        w_ctl;
    logic [6:0]       w_head;
    logic [CNT_W:0]   w_cnt_e;
    logic [CNT_W:0]   w_total_e;
    logic [CNT_W:0]   w_match_e;
    logic             w_out_free;
    logic             w_can_ins;
    logic [CNT_W-1:0] w_total_new;
    logic [7:0]       w_top_after;
    logic [CNT_W+4:0] w_count_wide;
    logic [7:0]       w_note_e;

    lnpv_stack u_stack (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    assign w_cnt_e    = {{(CNT_W + 1 - IDX_W){1'b0}}, r_cnt};
    assign w_match_e  = {{(CNT_W + 1 - IDX_W){1'b0}}, r_match};
    assign w_total_e  = {1'b0, r_total};
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_can_ins  = !r_found && (r_total != CNT_W'(STACK_DEPTH));
    assign w_note_e   = {1'b0, r_note};

    assign i_in.ready = (r_state == S_IDLE);

    // stack count and top of stack after this word
    always_comb begin
        w_total_new = r_total;
        w_top_after = NOTE_NONE;
        if (r_op == OP_PRESS) begin
            if (w_can_ins) begin
                w_total_new = r_total + 1'b1;
            end
        end else begin
            if (r_found) begin
                w_total_new = r_total - 1'b1;
                if (r_total > CNT_W'(1)) begin
                    w_top_after = ((w_match_e + 1'b1) == w_total_e) ? {1'b0, r_top2}
                                                                      : {1'b0, r_top1};
                end
            end else if (r_total != '0) begin
                w_top_after = {1'b0, r_top1};
            end
        end
    end

    assign w_count_wide = {5'b0, w_total_new};

    // cell control
    always_comb begin
        w_ctl.mode  = CM_HOLD;
        w_ctl.pos   = r_match;
        w_ctl.total = r_total;
        w_ctl.note  = r_note;
        if (r_state == S_SCAN) begin
            w_ctl.mode = CM_ROT;
        end else if ((r_state == S_UPD) && w_out_free) begin
            if ((r_op == OP_PRESS) && w_can_ins) begin
                w_ctl.mode = CM_INS;
            end else if ((r_op == OP_RELEASE) && r_found) begin
                w_ctl.mode = CM_DEL;
            end
        end
    end

    // sequencer and voice update
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_op         = r_op;
        n_note       = r_note;
        n_found      = r_found;
        n_match      = r_match;
        n_top1       = r_top1;
        n_top2       = r_top2;
        n_total      = r_total;
        n_voice_on   = r_voice_on;
        n_owner      = r_owner;
        n_prev       = r_prev;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_active = r_out_active;
        n_out_owner  = r_out_owner;
        n_out_event  = r_out_event;
        n_out_count  = r_out_count;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.op;
                    n_note  = i_in.note;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // slot r_cnt sits at the head of the ring this cycle
                if (!r_found && (w_cnt_e < w_total_e) && (w_head == r_note)) begin
                    n_found = 1'b1;
                    n_match = r_cnt;
                end
                if ((w_cnt_e + 1'b1) == w_total_e) begin
                    n_top1 = w_head;
                end
                if ((w_cnt_e + 2'd2) == w_total_e) begin
                    n_top2 = w_head;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(STACK_DEPTH - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_total     = w_total_new;
                    n_out_event = EV_NONE;
                    if (r_op == OP_PRESS) begin
                        if (r_voice_on && (r_prev != NOTE_NONE) && (r_owner != r_note)) begin
                            n_out_event = EV_GLIDE;
                        end else begin
                            n_out_event = EV_START;
                        end
                        n_voice_on = 1'b1;
                        n_owner    = r_note;
                        n_prev     = w_note_e;
                    end else if (!r_voice_on || (r_owner != r_note)) begin
                        if (r_prev == w_note_e) begin
                            n_prev = w_top_after;
                        end
                    end else if ((w_top_after != NOTE_NONE) && (w_top_after != w_note_e)) begin
                        // fall back to the newest key still held
                        n_owner     = w_top_after[6:0];
                        n_prev      = w_top_after;
                        n_out_event = EV_GLIDE;
                    end else begin
                        n_voice_on  = 1'b0;
                        n_owner     = 7'd0;
                        n_prev      = w_top_after;
                        n_out_event = EV_STOP;
                    end
                    n_out_valid  = 1'b1;
                    n_out_active = n_voice_on;
                    n_out_owner  = n_voice_on ? n_owner : 7'd0;
                    n_out_count  = w_count_wide[4:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_total     <= '0;
            r_voice_on  <= 1'b0;
            r_owner     <= 7'd0;
            r_prev      <= NOTE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_total     <= n_total;
            r_voice_on  <= n_voice_on;
            r_owner     <= n_owner;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_note       <= n_note;
        r_match      <= n_match;
        r_top1       <= n_top1;
        r_top2       <= n_top2;
        r_out_active <= n_out_active;
        r_out_owner  <= n_out_owner;
        r_out_event  <= n_out_event;
        r_out_count  <= n_out_count;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.voice_active = r_out_active;
    assign o_out.owner_note   = r_out_owner;
    assign o_out.voice_event  = r_out_event;
    assign o_out.held_count   = r_out_count;

    // held count never passes the stack depth
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(STACK_DEPTH))
        else $error("held count above stack depth");

    // a result word only appears out of the update step
    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_UPD)
        else $error("result word without update step");

    // a silent voice has no owner
    a_owner_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_voice_on |-> r_owner == 7'd0)
        else $error("owner set while voice is off");

    // an accepted key word starts the ring walk at slot zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SCAN) && (r_cnt == '0))
        else $error("ring walk did not start at slot zero");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lnpv_pkg::*;

    localparam int KEY_TARGET  = 1550;
    localparam int CALM_TAIL   = 150;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       op;
        logic [6:0] note;
    } key_word_t;

    typedef struct packed {
        logic       active;
        logic [6:0] owner;
        logic [1:0] ev;
        logic [4:0] count;
    } voice_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lnpv_in_if  key_if();
    lnpv_out_if voice_if();

    last_note_priority_voice_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_if),
        .o_out   (voice_if)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // stimulus and expectation stores
    key_word_t   key_backlog[$];
    voice_word_t voice_due[$];
    logic [6:0]  planned_held[$];
    int          keys_planned  = 0;
    int          keys_accepted = 0;
    int          voice_checked = 0;
    int          mismatches    = 0;
    int          cycle_count   = 0;
    logic        idle_on       = 1'b0;
    int          key_gap       = 0;
    int          voice_stall   = 0;

    // predicted block state
    logic [6:0]  key_stack[STACK_DEPTH];
    int          key_total     = 0;
    logic        voice_sounding = 1'b0;
    logic [6:0]  voice_note    = 7'd0;
    logic [7:0]  last_taken    = NOTE_NONE;

    // last-note-priority voice prediction for one key word
    function automatic voice_word_t predict_voice(input logic op, input logic [6:0] key);
        int          found;
        logic [7:0]  top;
        voice_word_t w;
        w.ev = EV_NONE;
        found = -1;
        for (int i = 0; i < key_total; i++) begin
            if (found < 0 && key_stack[i] == key) begin
                found = i;
            end
        end
        if (op == OP_PRESS) begin
            if (found < 0 && key_total < STACK_DEPTH) begin
                key_stack[key_total] = key;
                key_total++;
            end
            if (voice_sounding && last_taken != NOTE_NONE && voice_note != key) begin
                voice_note = key;
                w.ev = EV_GLIDE;
            end else begin
                voice_sounding = 1'b1;
                voice_note = key;
                w.ev = EV_START;
            end
            last_taken = {1'b0, key};
        end else begin
            // drop the key and close the gap
            if (found >= 0) begin
                for (int j = found; j + 1 < key_total; j++) begin
                    key_stack[j] = key_stack[j + 1];
                end
                key_total--;
            end
            top = (key_total == 0) ? NOTE_NONE : {1'b0, key_stack[key_total - 1]};
            if (!voice_sounding || voice_note != key) begin
                if (last_taken == {1'b0, key}) begin
                    last_taken = top;
                end
            end else if (top != NOTE_NONE && top != {1'b0, key}) begin
                voice_note = top[6:0];
                last_taken = top;
                w.ev = EV_GLIDE;
            end else begin
                voice_sounding = 1'b0;
                voice_note = 7'd0;
                last_taken = top;
                w.ev = EV_STOP;
            end
        end
        w.active = voice_sounding;
        w.owner  = voice_sounding ? voice_note : 7'd0;
        w.count  = key_total[4:0];
        return w;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at result %0d: got %0d, want %0d",
                 field, voice_checked, got, want);
        mismatches++;
    endtask

    // plan a key word and track which keys will be held
    task automatic queue_key(input logic op, input logic [6:0] note);
        key_word_t w;
        int        idx;
        w.op = op;
        w.note = note;
        key_backlog.push_back(w);
        keys_planned++;
        idx = -1;
        foreach (planned_held[i]) begin
            if (planned_held[i] == note) idx = i;
        end
        if (op == OP_PRESS) begin
            if (idx < 0 && planned_held.size() < STACK_DEPTH) planned_held.push_back(note);
        end else if (idx >= 0) begin
            planned_held.delete(idx);
        end
    endtask

    task automatic release_all();
        int pick;
        while (planned_held.size() > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_key(OP_RELEASE, 7'($urandom_range(0, 127)));
            end else begin
                pick = $urandom_range(0, planned_held.size() - 1);
                queue_key(OP_RELEASE, planned_held[pick]);
            end
        end
    endtask

    function automatic logic gaps_allowed();
        return idle_on && (key_backlog.size() > CALM_TAIL);
    endfunction

    // cycle count, idle phases and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) begin
            idle_on <= ($urandom_range(0, 3) != 0);
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("last_note_priority_voice_core verification failed");
            $finish;
        end
    end

    // key word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_if.valid <= 1'b0;
        end else begin
            if (key_if.valid && key_if.ready) begin
                voice_due.push_back(predict_voice(key_if.op, key_if.note));
                keys_accepted++;
            end
            if (!key_if.valid || key_if.ready) begin
                if (key_gap > 0) begin
                    key_if.valid <= 1'b0;
                    key_gap--;
                end else if (key_backlog.size() > 0) begin
                    key_if.valid <= 1'b1;
                    key_if.op    <= key_backlog[0].op;
                    key_if.note  <= key_backlog[0].note;
                    void'(key_backlog.pop_front());
                    if (gaps_allowed() && $urandom_range(0, 3) == 0) begin
                        key_gap = $urandom_range(1, 8);
                    end
                end else begin
                    key_if.valid <= 1'b0;
                end
            end
        end
    end

    // voice word monitor and checker
    always @(posedge i_clk) begin
        voice_word_t want;
        if (!i_rst_n) begin
            voice_if.ready <= 1'b0;
        end else begin
            if (voice_if.valid && voice_if.ready) begin
                if (voice_due.size() == 0) begin
                    report_mismatch("unexpected word", voice_if.voice_event, -1);
                end else begin
                    want = voice_due.pop_front();
                    if (voice_if.voice_active !== want.active)
                        report_mismatch("voice_active", voice_if.voice_active, want.active);
                    if (voice_if.owner_note !== want.owner)
                        report_mismatch("owner_note", voice_if.owner_note, want.owner);
                    if (voice_if.voice_event !== want.ev)
                        report_mismatch("voice_event", voice_if.voice_event, want.ev);
                    if (voice_if.held_count !== want.count)
                        report_mismatch("held_count", voice_if.held_count, want.count);
                end
                voice_checked++;
            end
            // stall bursts
            if (voice_stall > 0) begin
                voice_if.ready <= 1'b0;
                voice_stall--;
            end else begin
                voice_if.ready <= 1'b1;
                if (gaps_allowed() && $urandom_range(0, 5) == 0) begin
                    voice_stall = $urandom_range(1, 8);
                end
            end
        end
    end

    initial begin
        int base;
        int len;
        int pick;
        i_rst_n        = 1'b0;
        key_if.valid   = 1'b0;
        key_if.op      = OP_PRESS;
        key_if.note    = 7'd0;
        voice_if.ready = 1'b0;

        // directed: extremes, retrigger, glides, stop, stray releases
        queue_key(OP_PRESS, 7'd0);
        queue_key(OP_PRESS, 7'd0);
        queue_key(OP_PRESS, 7'd127);
        queue_key(OP_RELEASE, 7'd0);
        queue_key(OP_RELEASE, 7'd5);
        queue_key(OP_RELEASE, 7'd127);
        queue_key(OP_RELEASE, 7'd127);
        // fill the stack, then press with it full
        for (int i = 0; i < STACK_DEPTH; i++) begin
            queue_key(OP_PRESS, 7'(3 + 7 * i));
        end
        queue_key(OP_PRESS, 7'd42);
        queue_key(OP_RELEASE, 7'd42);

        // random phrases, stack fills and noise
        while (keys_planned < KEY_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                base = $urandom_range(0, 116);
                len = $urandom_range(4, 20);
                for (int i = 0; i < len; i++) begin
                    if (planned_held.size() > 0 && $urandom_range(0, 99) < 45) begin
                        if ($urandom_range(0, 9) != 0)
                            queue_key(OP_RELEASE,
                                      planned_held[$urandom_range(0, planned_held.size() - 1)]);
                        else
                            queue_key(OP_RELEASE, 7'(base + $urandom_range(0, 11)));
                    end else begin
                        queue_key(OP_PRESS, 7'(base + $urandom_range(0, 11)));
                    end
                end
            end else if (pick <= 7) begin
                len = $urandom_range(12, 20);
                for (int i = 0; i < len; i++) begin
                    queue_key(OP_PRESS, 7'($urandom_range(0, 127)));
                end
                release_all();
            end else if (pick == 8) begin
                len = $urandom_range(4, 12);
                for (int i = 0; i < len; i++) begin
                    queue_key(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                end
            end else begin
                release_all();
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain
        while (keys_accepted != keys_planned) @(posedge i_clk);
        while (voice_due.size() != 0) @(posedge i_clk);
        repeat (2 * STACK_DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("last_note_priority_voice_core verification clean");
        end else begin
            $display("last_note_priority_voice_core verification failed");
        end
        $finish;
    end

endmodule
